### hdl/lh3_pkg.sv
`default_nettype none
package lh3_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_BYTES = 12;

  localparam logic [WORD_W-1:0] START_CONST = 32'hdeadbeef;
  localparam logic [WORD_W-1:0] SEED_RESET  = 32'hbeefcafe;
  localparam logic [3:0]        TAIL_MAX    = 4'd12;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  // result queue on the output side
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_PTR_W = 1;

  // round pairs per pass: mix has 6 steps, final has 7
  localparam logic [1:0] MIX_LAST_STEP = 2'd2;
  localparam logic [1:0] FIN_LAST_STEP = 2'd3;

  // which accumulator a single mix/final step rewrites (a mix step also updates a second one)
  localparam logic [1:0] PAT_A = 2'd0;
  localparam logic [1:0] PAT_B = 2'd1;
  localparam logic [1:0] PAT_C = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } abc_t;

  typedef struct packed {
    logic  first;
    logic  last;
    logic  fin;
    word_t init;
    abc_t  w;
  } cmd_t;

  function automatic word_t rotl(input word_t x, input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  function automatic abc_t mix_sub(input abc_t s, input logic [1:0] pat,
                                   input int unsigned r);
    abc_t t;
    t = s;
    case (pat)
      PAT_A: begin
        t.a = (s.a - s.c) ^ rotl(s.c, r);
        t.c = s.c + s.b;
      end
      PAT_B: begin
        t.b = (s.b - s.a) ^ rotl(s.a, r);
        t.a = s.a + s.c;
      end
      PAT_C: begin
        t.c = (s.c - s.b) ^ rotl(s.b, r);
        t.b = s.b + s.a;
      end
      default: t = s;
    endcase
    return t;
  endfunction

  function automatic abc_t fin_sub(input abc_t s, input logic [1:0] pat,
                                   input int unsigned r);
    abc_t t;
    t = s;
    case (pat)
      PAT_A:   t.a = (s.a ^ s.c) - rotl(s.c, r);
      PAT_B:   t.b = (s.b ^ s.a) - rotl(s.a, r);
      PAT_C:   t.c = (s.c ^ s.b) - rotl(s.b, r);
      default: t = s;
    endcase
    return t;
  endfunction

  // two mix steps per call
  function automatic abc_t mix_pair(input logic [1:0] step, input abc_t s);
    abc_t t;
    t = s;
    case (step)
      2'd0: begin
        t = mix_sub(t, PAT_A, 4);
        t = mix_sub(t, PAT_B, 6);
      end
      2'd1: begin
        t = mix_sub(t, PAT_C, 8);
        t = mix_sub(t, PAT_A, 16);
      end
      2'd2: begin
        t = mix_sub(t, PAT_B, 19);
        t = mix_sub(t, PAT_C, 4);
      end
      default: t = s;
    endcase
    return t;
  endfunction

  // two final steps per call, the last call does one
  function automatic abc_t fin_pair(input logic [1:0] step, input abc_t s);
    abc_t t;
    t = s;
    case (step)
      2'd0: begin
        t = fin_sub(t, PAT_C, 14);
        t = fin_sub(t, PAT_A, 11);
      end
      2'd1: begin
        t = fin_sub(t, PAT_B, 25);
        t = fin_sub(t, PAT_C, 16);
      end
      2'd2: begin
        t = fin_sub(t, PAT_A, 4);
        t = fin_sub(t, PAT_B, 14);
      end
      default: t = fin_sub(t, PAT_C, 24);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

### hdl/lh3_front.sv
`default_nettype none
module lh3_front import lh3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire word_t       cfg_wr_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire word_t       in_word0,
  input  wire word_t       in_word1,
  input  wire word_t       in_word2,
  input  wire word_t       in_key_length,
  input  wire logic        in_first_block,
  input  wire logic        in_last_block,
  input  wire logic [3:0]  in_tail_bytes,
  output logic             cmd_valid,
  output cmd_t             cmd_head,
  input  wire logic        cmd_pop
);

  word_t                seed_r;
  cmd_t                 q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_PTR_W:0]   cnt_r, cnt_nxt;

  logic                     accept;
  logic                     take;
  logic [3:0]               tail_n;
  logic [BLOCK_BYTES-1:0]   byte_en;
  logic [8*BLOCK_BYTES-1:0] raw_w;
  logic [8*BLOCK_BYTES-1:0] masked_w;
  cmd_t                     entry;

  assign in_full   = (cnt_r == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_head  = q_r[rd_ptr_r];
  assign accept    = in_push && !in_full;
  assign take      = cmd_pop && cmd_valid;

  // classify the block: tail masking and start value
  always_comb begin
    tail_n = (in_tail_bytes > TAIL_MAX) ? TAIL_MAX : in_tail_bytes;
    raw_w  = {in_word2, in_word1, in_word0};
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      byte_en[i] = !in_last_block || (4'(i) < tail_n);
      masked_w[8*i +: 8] = byte_en[i] ? raw_w[8*i +: 8] : 8'h00;
    end
    entry.first = in_first_block;
    entry.last  = in_last_block;
    entry.fin   = in_last_block && (tail_n != 4'd0);
    entry.init  = START_CONST + in_key_length + seed_r;
    entry.w.a   = masked_w[WORD_W-1:0];
    entry.w.b   = masked_w[2*WORD_W-1:WORD_W];
    entry.w.c   = masked_w[3*WORD_W-1:2*WORD_W];
  end

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({accept, take})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

### hdl/lh3_back.sv
`default_nettype none
module lh3_back import lh3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_valid,
  input  wire cmd_t  cmd_head,
  output logic       cmd_pop,
  output logic       res_push,
  output word_t      res_data,
  input  wire logic  res_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  abc_t       acc_r, acc_nxt;

  abc_t base;
  abc_t sum;
  abc_t mixed;
  abc_t finned;
  logic start;

  always_comb begin
    base   = cmd_head.first ? {cmd_head.init, cmd_head.init, cmd_head.init} : acc_r;
    sum.a  = base.a + cmd_head.w.a;
    sum.b  = base.b + cmd_head.w.b;
    sum.c  = base.c + cmd_head.w.c;
    mixed  = mix_pair(step_r, acc_r);
    finned = fin_pair(step_r, acc_r);
    // an empty tail emits at once, so it needs room in the result queue
    start  = cmd_valid && !(cmd_head.last && !cmd_head.fin && res_full);

    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_data  = finned.c;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_pop  = 1'b1;
          acc_nxt  = sum;
          step_nxt = '0;
          if (!cmd_head.last) begin
            state_nxt = ST_MIX;
          end else if (cmd_head.fin) begin
            state_nxt = ST_FIN;
          end else begin
            res_push = 1'b1;
            res_data = sum.c;
          end
        end
      end
      ST_MIX: begin
        acc_nxt = mixed;
        if (step_r == MIX_LAST_STEP) begin
          state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (step_r != FIN_LAST_STEP) begin
          acc_nxt  = finned;
          step_nxt = step_r + 1'b1;
        end else if (!res_full) begin
          acc_nxt   = finned;
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/lh3_outq.sv
`default_nettype none
module lh3_outq import lh3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  res_push,
  input  wire word_t res_data,
  output logic       res_full,
  output logic       out_empty,
  input  wire logic  out_pop,
  output word_t      out_hash_value
);

  word_t                mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_PTR_W:0]   cnt_r, cnt_nxt;
  logic                 put;
  logic                 take;

  assign res_full       = (cnt_r == (RES_PTR_W+1)'(RES_DEPTH));
  assign out_empty      = (cnt_r == '0);
  assign out_hash_value = mem_r[rd_ptr_r];
  assign put            = res_push && !res_full;
  assign take           = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = put ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({put, take})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      mem_r[wr_ptr_r] <= res_data;
    end
  end

endmodule
`default_nettype wire

### hdl/lookup3_hash_engine.sv
// path: a block is written into the command queue; the back end pops it, adds it to a/b/c and, for a
//   last block, runs the final passes if it has tail bytes, then pushes the hash into the result queue,
//   where it shows; a hash also waits for every block queued ahead of it and while the result queue is full
// back end: a middle block is an add, then mix as 3 double rounds; a last block is an add, then final
//   as 4 passes; an empty tail is the add alone; the input side takes one block per cycle while the
//   4-entry command queue has room
// reset: synchronous, active low; clears both queues, a/b/c to zero and seed to 0xbeefcafe
`default_nettype none
module lookup3_hash_engine import lh3_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire word_t      cfg_wr_data,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire word_t      in_word0,
  input  wire word_t      in_word1,
  input  wire word_t      in_word2,
  input  wire word_t      in_key_length,
  input  wire logic       in_first_block,
  input  wire logic       in_last_block,
  input  wire logic [3:0] in_tail_bytes,
  output logic            out_empty,
  input  wire logic       out_pop,
  output word_t           out_hash_value
);

  logic  cmd_valid;
  cmd_t  cmd_head;
  logic  cmd_pop;
  logic  res_push;
  word_t res_data;
  logic  res_full;

  lh3_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_word0       (in_word0),
    .in_word1       (in_word1),
    .in_word2       (in_word2),
    .in_key_length  (in_key_length),
    .in_first_block (in_first_block),
    .in_last_block  (in_last_block),
    .in_tail_bytes  (in_tail_bytes),
    .cmd_valid      (cmd_valid),
    .cmd_head       (cmd_head),
    .cmd_pop        (cmd_pop)
  );

  lh3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  lh3_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_push       (res_push),
    .res_data       (res_data),
    .res_full       (res_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

endmodule
`default_nettype wire

### hdl/lh3_checker.sv
`default_nettype none
module lh3_checker import lh3_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_push,
  input wire logic       in_full,
  input wire logic       in_last_block,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire word_t      out_hash_value
);

  // last blocks taken in but whose hash has not yet been transferred out
  logic [3:0] pending_r, pending_nxt;
  logic       last_in;
  logic       res_out;

  assign last_in = in_push && !in_full && in_last_block;
  assign res_out = out_pop && !out_empty;

  always_comb begin
    case ({last_in, res_out})
      2'b10:   pending_nxt = pending_r + 1'b1;
      2'b01:   pending_nxt = pending_r - 1'b1;
      default: pending_nxt = pending_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_full_needs_push : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input side went full without a transfer");

  a_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_hash_value))
    else $error("waiting result changed before its transfer");

  a_no_orphan_result : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pending_r != 4'd0)
    else $error("result shown with no last block outstanding");

endmodule

bind lookup3_hash_engine lh3_checker u_lh3_checker (.*);
`default_nettype wire

### tb/tb_lookup3_hash_engine.sv
`timescale 1ns / 100ps

typedef struct {
  lh3_pkg::word_t word0;
  lh3_pkg::word_t word1;
  lh3_pkg::word_t word2;
  lh3_pkg::word_t key_length;
  logic           first_block;
  logic           last_block;
  logic [3:0]     tail_bytes;
} key_block_t;

class lookup3_hash_tracker;
  lh3_pkg::word_t acc_a;
  lh3_pkg::word_t acc_b;
  lh3_pkg::word_t acc_c;
  lh3_pkg::word_t seed;
  lh3_pkg::word_t hashes_due[$];
  int unsigned    bad_hashes;

  function new();
    acc_a = '0;
    acc_b = '0;
    acc_c = '0;
    seed = lh3_pkg::SEED_RESET;
    bad_hashes = 0;
  endfunction

  function void set_seed(lh3_pkg::word_t v);
    seed = v;
  endfunction

  function int unsigned due_count();
    return hashes_due.size();
  endfunction

  function lh3_pkg::word_t rot(lh3_pkg::word_t x, int unsigned k);
    logic [63:0] dbl;
    dbl = {x, x} << k;
    return dbl[63:32];
  endfunction

  // low n bytes of w, n may run negative or past 4
  function lh3_pkg::word_t keep_low(lh3_pkg::word_t w, int n);
    if (n >= 4) return w;
    if (n <= 0) return '0;
    return w & ((32'h1 << (8 * n)) - 32'h1);
  endfunction

  function void mix_six();
    acc_a -= acc_c; acc_a ^= rot(acc_c, 4);  acc_c += acc_b;
    acc_b -= acc_a; acc_b ^= rot(acc_a, 6);  acc_a += acc_c;
    acc_c -= acc_b; acc_c ^= rot(acc_b, 8);  acc_b += acc_a;
    acc_a -= acc_c; acc_a ^= rot(acc_c, 16); acc_c += acc_b;
    acc_b -= acc_a; acc_b ^= rot(acc_a, 19); acc_a += acc_c;
    acc_c -= acc_b; acc_c ^= rot(acc_b, 4);  acc_b += acc_a;
  endfunction

  function void avalanche();
    acc_c ^= acc_b; acc_c -= rot(acc_b, 14);
    acc_a ^= acc_c; acc_a -= rot(acc_c, 11);
    acc_b ^= acc_a; acc_b -= rot(acc_a, 25);
    acc_c ^= acc_b; acc_c -= rot(acc_b, 16);
    acc_a ^= acc_c; acc_a -= rot(acc_c, 4);
    acc_b ^= acc_a; acc_b -= rot(acc_a, 14);
    acc_c ^= acc_b; acc_c -= rot(acc_b, 24);
  endfunction

  function void take_block(key_block_t blk);
    lh3_pkg::word_t start;
    int             tail;
    if (blk.first_block) begin
      start = lh3_pkg::START_CONST + blk.key_length + seed;
      acc_a = start;
      acc_b = start;
      acc_c = start;
    end
    if (!blk.last_block) begin
      acc_a += blk.word0;
      acc_b += blk.word1;
      acc_c += blk.word2;
      mix_six();
      return;
    end
    tail = (blk.tail_bytes > lh3_pkg::TAIL_MAX) ? int'(lh3_pkg::TAIL_MAX)
                                                 : int'(blk.tail_bytes);
    // an empty tail hands back acc_c untouched
    if (tail != 0) begin
      acc_a += keep_low(blk.word0, tail);
      acc_b += keep_low(blk.word1, tail - 4);
      acc_c += keep_low(blk.word2, tail - 8);
      avalanche();
    end
    hashes_due.push_back(acc_c);
  endfunction

  function void match_hash(lh3_pkg::word_t got);
    lh3_pkg::word_t want;
    if (hashes_due.size() == 0) begin
      $error("hash_value transfer with none expected: got %08h", got);
      bad_hashes++;
      return;
    end
    want = hashes_due.pop_front();
    if (got !== want) begin
      $error("hash_value mismatch: expected %08h, actual %08h", want, got);
      bad_hashes++;
    end
  endfunction
endclass

module tb_lookup3_hash_engine;
  import lh3_pkg::*;

  localparam int unsigned PHASES         = 4;
  localparam int unsigned BLOCKS_PER_PHASE = 485;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  word_t      cfg_wr_data;
  logic       in_push;
  logic       in_full;
  word_t      in_word0;
  word_t      in_word1;
  word_t      in_word2;
  word_t      in_key_length;
  logic       in_first_block;
  logic       in_last_block;
  logic [3:0] in_tail_bytes;
  logic       out_empty;
  logic       out_pop = 1'b0;
  word_t      out_hash_value;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  lookup3_hash_tracker hash_track;

  lookup3_hash_engine u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_word0       (in_word0),
    .in_word1       (in_word1),
    .in_word2       (in_word2),
    .in_key_length  (in_key_length),
    .in_first_block (in_first_block),
    .in_last_block  (in_last_block),
    .in_tail_bytes  (in_tail_bytes),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: check each transfer, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      hash_track.match_hash(out_hash_value);
    end
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("lookup3_hash_engine regression: fail");
    $finish;
  end

  function automatic key_block_t mk_block(word_t w0, word_t w1, word_t w2, word_t len,
                                          logic first, logic last, logic [3:0] tail);
    key_block_t blk;
    blk.word0 = w0;
    blk.word1 = w1;
    blk.word2 = w2;
    blk.key_length = len;
    blk.first_block = first;
    blk.last_block = last;
    blk.tail_bytes = tail;
    return blk;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input key_block_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word0 <= blk.word0;
    in_word1 <= blk.word1;
    in_word2 <= blk.word2;
    in_key_length <= blk.key_length;
    in_first_block <= blk.first_block;
    in_last_block <= blk.last_block;
    in_tail_bytes <= blk.tail_bytes;
    @(posedge clk);
    while (in_full) @(posedge clk);
    hash_track.take_block(blk);
  endtask

  // mostly whole keys with random content, some loose blocks with random flags
  task automatic send_random_key(inout int unsigned sent);
    key_block_t  blk;
    int unsigned nblk;
    int unsigned tail;
    word_t       len;
    if ($urandom_range(99) < 12) begin
      blk = mk_block(pick_word(), pick_word(), pick_word(), $urandom,
                     1'($urandom_range(1)), 1'($urandom_range(1)), 4'($urandom_range(15)));
      send_block(blk);
      sent++;
      return;
    end
    nblk = $urandom_range(4);
    if ($urandom_range(19) == 0) nblk = $urandom_range(12, 5);
    if (nblk == 0) begin
      len = ($urandom_range(3) == 0) ? word_t'($urandom) : '0;
      send_block(mk_block(pick_word(), pick_word(), pick_word(), len, 1'b1, 1'b1, 4'd0));
      sent++;
      return;
    end
    tail = $urandom_range(12, 1);
    len = (nblk - 1) * 12 + tail;
    if ($urandom_range(9) == 0) len = $urandom;
    for (int unsigned i = 0; i < nblk; i++) begin
      blk = mk_block(pick_word(), pick_word(), pick_word(), (i == 0) ? len : $urandom,
                     i == 0, i == nblk - 1, 4'($urandom_range(15)));
      if (blk.last_block) begin
        blk.tail_bytes = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13)) : 4'(tail);
      end
      send_block(blk);
      sent++;
    end
  endtask

  task automatic settle_then_seed(input word_t v);
    in_push <= 1'b0;
    while (hash_track.due_count() != 0) @(posedge clk);
    // middle blocks give no result but may still be in the back end
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hash_track.set_seed(v);
  endtask

  task automatic send_directed();
    send_block(mk_block('0, '0, '0, '0, 1'b1, 1'b1, 4'd0));
    for (int t = 1; t <= 12; t++) begin
      if (t % 2 == 0) begin
        send_block(mk_block('1, '1, '1, word_t'(t), 1'b1, 1'b1, 4'(t)));
      end else begin
        send_block(mk_block($urandom, $urandom, $urandom, word_t'(t), 1'b1, 1'b1, 4'(t)));
      end
    end
    // oversized tails count as full blocks
    send_block(mk_block('1, '1, '1, 32'd12, 1'b1, 1'b1, 4'd13));
    send_block(mk_block($urandom, $urandom, $urandom, 32'd12, 1'b1, 1'b1, 4'd15));
    // middle block tail field is ignored
    send_block(mk_block($urandom, $urandom, $urandom, 32'd19, 1'b1, 1'b0, 4'd7));
    send_block(mk_block($urandom, $urandom, $urandom, '0, 1'b0, 1'b1, 4'd7));
    send_block(mk_block('0, '0, '0, '1, 1'b1, 1'b0, 4'd0));
    send_block(mk_block('0, '0, '0, '0, 1'b0, 1'b0, 4'd15));
    send_block(mk_block('0, '0, '0, '0, 1'b0, 1'b1, 4'd12));
    // keys with no first block carry on from the finished hash
    send_block(mk_block($urandom, $urandom, $urandom, '1, 1'b0, 1'b1, 4'd5));
    send_block(mk_block($urandom, $urandom, $urandom, '0, 1'b0, 1'b0, 4'd3));
    send_block(mk_block('1, '1, '1, '1, 1'b0, 1'b1, 4'd0));
  endtask

  initial begin
    int unsigned sent;
    hash_track = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_push = 1'b0;
    in_word0 = '0;
    in_word1 = '0;
    in_word2 = '0;
    in_key_length = '0;
    in_first_block = 1'b0;
    in_last_block = 1'b0;
    in_tail_bytes = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: settle_then_seed('0);
        2: settle_then_seed('1);
        3: settle_then_seed($urandom);
        default: ;
      endcase
      send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 27 : 0;
      if (ph == 0) send_directed();
      sent = 0;
      while (sent < BLOCKS_PER_PHASE) send_random_key(sent);
    end

    in_push <= 1'b0;
    while (hash_track.due_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hash_track.bad_hashes == 0) begin
      $display("lookup3_hash_engine regression: pass");
    end else begin
      $display("lookup3_hash_engine regression: fail");
    end
    $finish;
  end

endmodule
